FILE: hdl/fitf_pkg.sv
// Shared types and constants for the FSK ID tone framer.
// No dependencies; every other file of the block uses it.
package fitf_pkg;

    localparam int CODE_W       = 8;
    localparam int SYM_W        = 6;
    localparam int HZ_W         = 12;
    localparam int MS_W         = 9;

    localparam int MAX_ID_CHARS = 16;
    localparam int CNT_W        = $clog2(MAX_ID_CHARS + 1);

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int BIT_W        = $clog2(SYM_W);

    localparam logic [CODE_W-1:0] CODE_LO   = 8'h20;
    localparam logic [CODE_W-1:0] CODE_HI   = 8'h5F;
    localparam logic [SYM_W-1:0]  SYM_START = 6'h2A;
    localparam logic [SYM_W-1:0]  SYM_END   = 6'h01;
    localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(SYM_W - 1);

    localparam logic [HZ_W-1:0] HZ_LOW  = 12'd1500;
    localparam logic [HZ_W-1:0] HZ_ONE  = 12'd1900;
    localparam logic [HZ_W-1:0] HZ_ZERO = 12'd2100;
    localparam logic [MS_W-1:0] MS_BIT  = 9'd22;
    localparam logic [MS_W-1:0] MS_MID  = 9'd100;
    localparam logic [MS_W-1:0] MS_LONG = 9'd300;

    // One queued job: everything the back end needs to play out one character.
    typedef struct packed {
        logic             do_pre;
        logic             do_sym;
        logic [SYM_W-1:0] sym;
        logic             do_close;
        logic [SYM_W-1:0] csum;
    } job_t;

    typedef enum logic [2:0] {
        PH_LOW,
        PH_MID,
        PH_SYNC,
        PH_START,
        PH_DATA,
        PH_END,
        PH_CSUM,
        PH_TAIL
    } phase_t;

endpackage

FILE: hdl/fitf_char_if.sv
// Character input channel: valid/ready handshake with one ID character.
// Depends on fitf_pkg for field widths.
interface fitf_char_if;
    logic                        valid;
    logic                        ready;
    logic [fitf_pkg::CODE_W-1:0] char_code;
    logic                        last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

FILE: hdl/fitf_tone_if.sv
// Tone output channel: valid/ready handshake with one tone segment.
// Depends on fitf_pkg for field widths.
interface fitf_tone_if;
    logic                      valid;
    logic                      ready;
    logic [fitf_pkg::HZ_W-1:0] tone_hz;
    logic [fitf_pkg::MS_W-1:0] tone_ms;
    logic                      run_end;

    modport source (output valid, tone_hz, tone_ms, run_end, input ready);
    modport sink   (input valid, tone_hz, tone_ms, run_end, output ready);
endinterface

FILE: hdl/fitf_front.sv
// Front end: accepts characters, keeps the text state and queues play-out jobs.
// Depends on fitf_pkg and fitf_char_if.
module fitf_front
(
    input  logic               clk,
    input  logic               rst_n,
    fitf_char_if.sink          char_in,
    input  logic               q_full,
    output logic               push_valid,
    output fitf_pkg::job_t     push_job
);

    logic                           sent_reg, sent_next;
    logic [fitf_pkg::SYM_W-1:0]     xor_reg, xor_next;
    logic [fitf_pkg::CNT_W-1:0]     seen_reg, seen_next;

    logic                           xfer;
    logic                           counted;
    logic                           is_sym;
    logic [fitf_pkg::SYM_W-1:0]     sym;
    logic                           sent_upd;
    logic [fitf_pkg::SYM_W-1:0]     xor_upd;
    logic                           close;

    assign char_in.ready = !q_full;
    assign xfer          = char_in.valid && char_in.ready;

    always_comb
    begin
        counted  = seen_reg < fitf_pkg::CNT_W'(fitf_pkg::MAX_ID_CHARS);
        is_sym   = counted && (char_in.char_code >= fitf_pkg::CODE_LO)
                           && (char_in.char_code <= fitf_pkg::CODE_HI);
        sym      = fitf_pkg::SYM_W'(char_in.char_code - fitf_pkg::CODE_LO);
        sent_upd = sent_reg || is_sym;
        xor_upd  = is_sym ? (xor_reg ^ sym) : xor_reg;
        close    = char_in.last_char && sent_upd;

        push_job.do_pre   = is_sym && !sent_reg;
        push_job.do_sym   = is_sym;
        push_job.sym      = sym;
        push_job.do_close = close;
        push_job.csum     = xor_upd;
        push_valid        = xfer && (is_sym || close);

        sent_next = sent_reg;
        xor_next  = xor_reg;
        seen_next = seen_reg;
        if (xfer)
        begin
            if (char_in.last_char)
            begin
                // end of text: back to the idle text state
                sent_next = 1'b0;
                xor_next  = '0;
                seen_next = '0;
            end
            else
            begin
                sent_next = sent_upd;
                xor_next  = xor_upd;
                seen_next = counted ? seen_reg + 1'b1 : seen_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= 1'b0;
            xor_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            sent_reg <= sent_next;
            xor_reg  <= xor_next;
            seen_reg <= seen_next;
        end
    end

    a_seen_limit: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= fitf_pkg::CNT_W'(fitf_pkg::MAX_ID_CHARS))
        else $error("character count passed the limit");

endmodule

FILE: hdl/fitf_queue.sv
// Short job queue between front and back end, built from flip-flops.
// Depends on fitf_pkg for the job type and depth.
module fitf_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fitf_pkg::job_t     push_job,
    input  logic               pop,
    output fitf_pkg::job_t     head_job,
    output logic               full,
    output logic               empty
);

    fitf_pkg::job_t                  slots_reg [fitf_pkg::QUEUE_DEPTH];
    logic [fitf_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [fitf_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [fitf_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign full     = cnt_reg == fitf_pkg::QCNT_W'(fitf_pkg::QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign head_job = slots_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == fitf_pkg::QPTR_W'(fitf_pkg::QUEUE_DEPTH - 1))
                      ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == fitf_pkg::QPTR_W'(fitf_pkg::QUEUE_DEPTH - 1))
                      ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job popped from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

FILE: hdl/fitf_back.sv
// Back end: plays each queued job out as tone segments, one per cycle while the output is taken.
// Depends on fitf_pkg and fitf_tone_if.
module fitf_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  fitf_pkg::job_t     head_job,
    input  logic               q_empty,
    output logic               pop,
    fitf_tone_if.source        tone_out
);

    logic                          busy_reg, busy_next;
    fitf_pkg::phase_t              phase_reg, phase_next;
    logic [fitf_pkg::BIT_W-1:0]    bit_reg, bit_next;
    fitf_pkg::job_t                job_reg;

    logic                          out_valid_reg;
    logic [fitf_pkg::HZ_W-1:0]     hz_reg;
    logic [fitf_pkg::MS_W-1:0]     ms_reg;
    logic                          end_reg;

    fitf_pkg::job_t                cur_job;
    fitf_pkg::phase_t              cur_phase;
    fitf_pkg::phase_t              first_phase;
    fitf_pkg::phase_t              adv_phase;
    logic [fitf_pkg::BIT_W-1:0]    cur_bit;
    logic [fitf_pkg::BIT_W-1:0]    adv_bit;
    logic [fitf_pkg::SYM_W-1:0]    sym_val;
    logic [fitf_pkg::HZ_W-1:0]     hz;
    logic [fitf_pkg::MS_W-1:0]     ms;
    logic                          done;
    logic                          fire;

    assign tone_out.valid   = out_valid_reg;
    assign tone_out.tone_hz = hz_reg;
    assign tone_out.tone_ms = ms_reg;
    assign tone_out.run_end = end_reg;

    assign fire = (!out_valid_reg || tone_out.ready) && (busy_reg || !q_empty);
    assign pop  = fire && !busy_reg;

    always_comb
    begin
        // start a fresh job straight from the queue head, no bubble
        priority if (head_job.do_pre)
        begin
            first_phase = fitf_pkg::PH_LOW;
        end
        else if (head_job.do_sym)
        begin
            first_phase = fitf_pkg::PH_DATA;
        end
        else
        begin
            first_phase = fitf_pkg::PH_END;
        end

        cur_job   = busy_reg ? job_reg : head_job;
        cur_phase = busy_reg ? phase_reg : first_phase;
        cur_bit   = busy_reg ? bit_reg : '0;

        unique case (cur_phase)
            fitf_pkg::PH_START: sym_val = fitf_pkg::SYM_START;
            fitf_pkg::PH_DATA:  sym_val = cur_job.sym;
            fitf_pkg::PH_END:   sym_val = fitf_pkg::SYM_END;
            fitf_pkg::PH_CSUM:  sym_val = cur_job.csum;
            default:            sym_val = '0;
        endcase

        hz        = sym_val[cur_bit] ? fitf_pkg::HZ_ONE : fitf_pkg::HZ_ZERO;
        ms        = fitf_pkg::MS_BIT;
        done      = 1'b0;
        adv_phase = cur_phase;
        adv_bit   = '0;

        unique case (cur_phase)
            fitf_pkg::PH_LOW:
            begin
                hz        = fitf_pkg::HZ_LOW;
                ms        = fitf_pkg::MS_LONG;
                adv_phase = fitf_pkg::PH_MID;
            end
            fitf_pkg::PH_MID:
            begin
                hz        = fitf_pkg::HZ_ZERO;
                ms        = fitf_pkg::MS_MID;
                adv_phase = fitf_pkg::PH_SYNC;
            end
            fitf_pkg::PH_SYNC:
            begin
                hz        = fitf_pkg::HZ_ONE;
                adv_phase = fitf_pkg::PH_START;
            end
            fitf_pkg::PH_TAIL:
            begin
                hz   = fitf_pkg::HZ_ONE;
                ms   = fitf_pkg::MS_MID;
                done = 1'b1;
            end
            fitf_pkg::PH_START, fitf_pkg::PH_DATA,
            fitf_pkg::PH_END, fitf_pkg::PH_CSUM:
            begin
                if (cur_bit != fitf_pkg::BIT_LAST)
                begin
                    adv_bit = cur_bit + 1'b1;
                end
                else
                begin
                    unique case (cur_phase)
                        fitf_pkg::PH_START: adv_phase = fitf_pkg::PH_DATA;
                        fitf_pkg::PH_DATA:
                        begin
                            adv_phase = fitf_pkg::PH_END;
                            done      = !cur_job.do_close;
                        end
                        fitf_pkg::PH_END:   adv_phase = fitf_pkg::PH_CSUM;
                        default:            adv_phase = fitf_pkg::PH_TAIL;
                    endcase
                end
            end
        endcase

        busy_next  = busy_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        if (fire)
        begin
            busy_next  = !done;
            phase_next = adv_phase;
            bit_next   = adv_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= fitf_pkg::PH_LOW;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tone_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: load the output slot and hold the current job
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hz_reg  <= hz;
            ms_reg  <= ms;
            end_reg <= done;
            job_reg <= cur_job;
        end
    end

    a_busy_shows_tone: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> out_valid_reg)
        else $error("job in progress with empty output slot");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !busy_reg)
        else $error("queue popped while a job is in progress");

endmodule

FILE: hdl/fsk_id_tone_framer_unit.sv
// A character is accepted whenever the job queue (four entries) has room.
// A character that becomes a symbol yields six 22 ms tones; the first symbol of a text adds a
// nine-tone preamble, and the last character of a text adds thirteen closing tones, so one
// character yields 0 to 28 tones. The back-end sequencer puts out one tone per cycle with no
// gap between jobs, while the tone receiver is ready.
// Skipped characters and characters past sixteen yield no tones unless they end a text.
// Top level: joins front end, job queue and back-end sequencer.
// Depends on fitf_pkg, fitf_char_if, fitf_tone_if, fitf_front, fitf_queue, fitf_back.
module fsk_id_tone_framer_unit
(
    input  logic         clk,
    input  logic         rst_n,
    fitf_char_if.sink    char_in,
    fitf_tone_if.source  tone_out
);

    logic              q_full;
    logic              q_empty;
    logic              push_valid;
    logic              pop;
    fitf_pkg::job_t    push_job;
    fitf_pkg::job_t    head_job;

    fitf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    fitf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    fitf_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_empty),
        .pop      (pop),
        .tone_out (tone_out)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for fsk_id_tone_framer_unit: a directed table, then random ID texts.
// Tones are predicted per accepted character and compared in order on the tone channel.
// Depends on fitf_pkg, fitf_char_if, fitf_tone_if and the framer RTL.
module tb_top;

    localparam int N_RANDOM     = 320;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_EVERY   = 700;
    localparam int NO_COUNT     = -1;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [fitf_pkg::HZ_W-1:0] hz;
        logic [fitf_pkg::MS_W-1:0] ms;
        logic                      run_end;
    } tone_t;

    typedef struct {
        logic [fitf_pkg::CODE_W-1:0] code;
        logic                        last;
        int                          n_tones;
    } dir_row_t;

    logic clk;
    logic rst_n;

    fitf_char_if char_bus();
    fitf_tone_if tone_bus();

    fsk_id_tone_framer_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus.sink),
        .tone_out (tone_bus.source)
    );

    // Framer state as the bench sees it
    logic                       pre_sent;
    logic [fitf_pkg::SYM_W-1:0] csum_acc;
    logic [4:0]                 chars_cnt;

    tone_t tones_due[$];
    int    n_errors;
    int    tones_seen;
    int    chars_sent;
    int    texts_closed;
    int    burst_left;

    // Skipped characters, a closing with nothing sent, the longest output and a text
    // running past the sixteen-character limit.
    dir_row_t dir_tab[DIR_ROWS] = '{
        '{8'h00, 1'b1, 0},
        '{8'h20, 1'b0, 15},
        '{8'h5F, 1'b0, 6},
        '{8'h60, 1'b0, 0},
        '{8'hFF, 1'b0, 0},
        '{8'h1F, 1'b1, 13},
        '{8'h20, 1'b1, 28},
        '{8'h5F, 1'b1, 28},
        '{8'h80, 1'b0, 0},
        '{8'h41, 1'b0, NO_COUNT},
        '{8'h42, 1'b0, NO_COUNT},
        '{8'h43, 1'b0, NO_COUNT},
        '{8'h44, 1'b0, NO_COUNT},
        '{8'h45, 1'b0, NO_COUNT},
        '{8'h46, 1'b0, NO_COUNT},
        '{8'h47, 1'b0, NO_COUNT},
        '{8'h48, 1'b0, NO_COUNT},
        '{8'h49, 1'b0, NO_COUNT},
        '{8'h4A, 1'b0, NO_COUNT},
        '{8'h4B, 1'b0, NO_COUNT},
        '{8'h4C, 1'b0, NO_COUNT},
        '{8'h4D, 1'b0, NO_COUNT},
        '{8'h4E, 1'b0, NO_COUNT},
        '{8'h4F, 1'b0, 6},
        '{8'h50, 1'b1, 13}
    };

    always #5 clk = ~clk;

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic queue_tone(input logic [fitf_pkg::HZ_W-1:0] hz,
                              input logic [fitf_pkg::MS_W-1:0] ms,
                              inout int n);
        tone_t t;
        t.hz      = hz;
        t.ms      = ms;
        t.run_end = 1'b0;
        tones_due.push_back(t);
        n++;
    endtask

    task automatic queue_symbol(input logic [fitf_pkg::SYM_W-1:0] sym, inout int n);
        for (int b = 0; b < fitf_pkg::SYM_W; b++)
        begin
            queue_tone(sym[b] ? fitf_pkg::HZ_ONE : fitf_pkg::HZ_ZERO, fitf_pkg::MS_BIT, n);
        end
    endtask

    // Predict the tones of one accepted character; counted is low for characters
    // that only fall past the limit without closing the text.
    task automatic frame_char(input logic [fitf_pkg::CODE_W-1:0] code, input logic last,
                              output int n, output bit counted);
        logic [fitf_pkg::SYM_W-1:0] sym;
        n       = 0;
        counted = last;
        if (chars_cnt < 5'(fitf_pkg::MAX_ID_CHARS))
        begin
            counted   = 1'b1;
            chars_cnt = chars_cnt + 5'd1;
            if (code >= fitf_pkg::CODE_LO && code <= fitf_pkg::CODE_HI)
            begin
                sym = fitf_pkg::SYM_W'(code - fitf_pkg::CODE_LO);
                if (!pre_sent)
                begin
                    queue_tone(fitf_pkg::HZ_LOW, fitf_pkg::MS_LONG, n);
                    queue_tone(fitf_pkg::HZ_ZERO, fitf_pkg::MS_MID, n);
                    queue_tone(fitf_pkg::HZ_ONE, fitf_pkg::MS_BIT, n);
                    queue_symbol(fitf_pkg::SYM_START, n);
                    pre_sent = 1'b1;
                end
                queue_symbol(sym, n);
                csum_acc = csum_acc ^ sym;
            end
        end
        if (last)
        begin
            if (pre_sent)
            begin
                queue_symbol(fitf_pkg::SYM_END, n);
                queue_symbol(csum_acc, n);
                queue_tone(fitf_pkg::HZ_ONE, fitf_pkg::MS_MID, n);
            end
            pre_sent  = 1'b0;
            csum_acc  = '0;
            chars_cnt = '0;
            texts_closed++;
        end
        if (n > 0)
        begin
            tones_due[tones_due.size() - 1].run_end = 1'b1;
        end
    endtask

    // Offer one character, inside a burst or after a random gap, and predict on transfer.
    task automatic send_char(input logic [fitf_pkg::CODE_W-1:0] code, input logic last,
                             output int n, output bit counted);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                char_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        char_bus.last_char <= last;
        @(posedge clk);
        while (!char_bus.ready) @(posedge clk);
        chars_sent++;
        frame_char(code, last, n, counted);
    endtask

    // Hold the input until every predicted tone has been taken.
    task automatic drain_tones();
        char_bus.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (tones_due.size() != 0);
    endtask

    // Tone checker
    always @(posedge clk)
    begin
        tone_t want;
        if (rst_n && tone_bus.valid && tone_bus.ready)
        begin
            tones_seen++;
            if (tones_due.size() == 0)
            begin
                note_error($sformatf("unexpected tone hz=%0d ms=%0d run_end=%0b",
                                     tone_bus.tone_hz, tone_bus.tone_ms, tone_bus.run_end));
            end
            else
            begin
                want = tones_due.pop_front();
                if (tone_bus.tone_hz !== want.hz)
                    note_error($sformatf("tone %0d hz exp %0d got %0d",
                                         tones_seen, want.hz, tone_bus.tone_hz));
                if (tone_bus.tone_ms !== want.ms)
                    note_error($sformatf("tone %0d ms exp %0d got %0d",
                                         tones_seen, want.ms, tone_bus.tone_ms));
                if (tone_bus.run_end !== want.run_end)
                    note_error($sformatf("tone %0d run_end exp %0b got %0b",
                                         tones_seen, want.run_end, tone_bus.run_end));
            end
        end
    end

    // Tone receiver: stalls in changing patterns, plus a long hold every so often
    initial
    begin
        int hold_left;
        int next_hold;
        int rx_mode;
        int mode_left;
        hold_left      = 0;
        next_hold      = HOLD_EVERY;
        rx_mode        = 0;
        mode_left      = 0;
        tone_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                tone_bus.ready <= 1'b0;
            end
            else if (tones_seen >= next_hold)
            begin
                hold_left = HOLD_CYCLES;
                next_hold = next_hold + HOLD_EVERY;
                tone_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (rx_mode)
                    0:       tone_bus.ready <= 1'b1;
                    1:       tone_bus.ready <= 1'($urandom_range(0, 1));
                    2:       tone_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: tone_bus.ready <= (mode_left % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int                          n;
        bit                          counted;
        int                          rand_items;
        int                          text_len;
        logic [fitf_pkg::CODE_W-1:0] code;
        logic                        last;
        bit                          paused;

        clk                = 1'b0;
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.last_char = 1'b0;
        pre_sent           = 1'b0;
        csum_acc           = '0;
        chars_cnt          = '0;
        n_errors           = 0;
        tones_seen         = 0;
        chars_sent         = 0;
        texts_closed       = 0;
        burst_left         = 0;
        rand_items         = 0;
        paused             = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_char(dir_tab[i].code, dir_tab[i].last, n, counted);
            if (dir_tab[i].n_tones != NO_COUNT && n != dir_tab[i].n_tones)
                note_error($sformatf("row %0d code %02h tone count exp %0d predicted %0d",
                                     i, dir_tab[i].code, dir_tab[i].n_tones, n));
        end
        drain_tones();

        // Mostly well-formed texts of printable codes, some long, some broken early
        while (rand_items < N_RANDOM)
        begin
            text_len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20)
                                                  : $urandom_range(1, 8);
            for (int k = 0; k < text_len; k++)
            begin
                if ($urandom_range(0, 4) != 0)
                    code = fitf_pkg::CODE_W'($urandom_range(fitf_pkg::CODE_LO,
                                                            fitf_pkg::CODE_HI));
                else
                    code = fitf_pkg::CODE_W'($urandom_range(0, 255));
                last = (k == text_len - 1) || ($urandom_range(0, 39) == 0);
                send_char(code, last, n, counted);
                if (counted)
                    rand_items++;
            end
            if (!paused && rand_items >= N_RANDOM / 2)
            begin
                paused = 1'b1;
                drain_tones();
            end
        end
        char_bus.valid <= 1'b0;

        while (tones_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d characters in %0d closed texts, checked %0d tones, %0d errors",
                 chars_sent, texts_closed, tones_seen, n_errors);
        if (n_errors == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

FILE: fsk_id_tone_framer_unit.f
hdl/fitf_pkg.sv
hdl/fitf_char_if.sv
hdl/fitf_tone_if.sv
hdl/fitf_front.sv
hdl/fitf_queue.sv
hdl/fitf_back.sv
hdl/fsk_id_tone_framer_unit.sv
tb/tb_top.sv
